### design/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sgs checker: assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sgs checker: assertion failed");

`endif

### design/sgs_pkg.sv
package sgs_pkg;

  // Fixed-point formats and timing
  localparam int PHASE_BITS        = 16;
  localparam int SINE_TABLE_DEPTH  = 256;
  localparam int TICK_MILLISECONDS = 32;

  localparam int IDX_BITS  = $clog2(SINE_TABLE_DEPTH);
  localparam int QUARTER   = SINE_TABLE_DEPTH / 4;
  localparam int QIDX_BITS = IDX_BITS - 2;
  localparam int LUT_BITS  = QIDX_BITS + 1;
  localparam int SINE_BITS = 15;

  // One in Q30, the scale of the sine polynomial
  localparam longint Q30_ONE = 64'sd1073741824;

  localparam int TICK_BITS = 12;
  localparam logic [TICK_BITS-1:0] TICKS_MAX = '1;

  localparam int STEP_BITS = 4;
  localparam int AMP_BITS  = 15;
  localparam int ID_BITS   = 3;
  localparam int PROD_BITS = AMP_BITS + SINE_BITS;
  localparam int QUOT_BITS = 16;

  // Timetable steps
  localparam logic [STEP_BITS-1:0] STEP_FORWARD        = 4'd0;
  localparam logic [STEP_BITS-1:0] STEP_BACKWARD       = 4'd1;
  localparam logic [STEP_BITS-1:0] STEP_PAUSE_A        = 4'd2;
  localparam logic [STEP_BITS-1:0] STEP_ROTATE_CW      = 4'd3;
  localparam logic [STEP_BITS-1:0] STEP_ROTATE_CCW     = 4'd4;
  localparam logic [STEP_BITS-1:0] STEP_PAUSE_B        = 4'd5;
  localparam logic [STEP_BITS-1:0] STEP_SIDEWIND_LEFT  = 4'd6;
  localparam logic [STEP_BITS-1:0] STEP_SIDEWIND_RIGHT = 4'd7;
  localparam logic [STEP_BITS-1:0] STEP_PAUSE_C        = 4'd8;
  localparam logic [STEP_BITS-1:0] STEP_FINISHED       = 4'd9;
  localparam int NUM_DEADLINES = 9;

  // Register indexes and reset values
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODULE_ID  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_AMPLITUDE  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_STEP = 2'd2;
  localparam logic [ID_BITS-1:0]    MODULE_ID_RST  = 3'd0;
  localparam logic [AMP_BITS-1:0]   AMPLITUDE_RST  = 15'd14746;
  localparam logic [PHASE_BITS-1:0] PHASE_STEP_RST = PHASE_BITS'(2097);

  // Phase offsets come in 1/72 turn
  localparam int OFFSET_STEPS = 72;
  localparam int OFFSET_BITS  = $clog2(OFFSET_STEPS);

  // Rounding division of amp * sin by 16384 * k
  localparam int ROUND_SHIFT_ONE  = 14;
  localparam int ROUND_SHIFT_FOUR = 16;
  localparam logic [PROD_BITS-1:0] BIAS_ONE   = PROD_BITS'(8192);
  localparam logic [PROD_BITS-1:0] BIAS_THREE = PROD_BITS'(24576);
  localparam logic [PROD_BITS-1:0] BIAS_FOUR  = PROD_BITS'(32768);
  localparam logic [QUOT_BITS-1:0] RECIP_THIRD = 16'd43691;
  localparam int RECIP_SHIFT = 17;

  // Queue between front and back
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    DIV_ONE   = 2'd0,
    DIV_THREE = 2'd1,
    DIV_FOUR  = 2'd2
  } div_e;

  typedef struct packed {
    logic [IDX_BITS-1:0]  idx;
    logic [STEP_BITS-1:0] step;
    div_e                 div;
    logic                 zero;
  } cmd_t;

  typedef logic [SINE_BITS-1:0]  sine_lut_t     [0:QUARTER];
  typedef logic [PHASE_BITS-1:0] offset_lut_t   [0:OFFSET_STEPS-1];
  typedef logic [31:0]           deadline_lut_t [0:(1<<STEP_BITS)-1];
  typedef int                    deadline_ms_t  [0:NUM_DEADLINES-1];

  localparam deadline_ms_t DEADLINE_MS = '{
    10000, 20000, 22000, 29000, 36000, 38000, 45000, 52000, 62000};

  // Quarter-wave sine in Q2.14 from an odd polynomial in Q30
  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    longint    u;
    longint    u2;
    longint    r;
    for (int k = 0; k <= QUARTER; k++) begin
      u  = (longint'(k) * 4 * Q30_ONE) / SINE_TABLE_DEPTH;
      u2 = (u * u) / Q30_ONE;
      r  = 61;
      r  = (r * u2) / Q30_ONE - 3864;
      r  = (r * u2) / Q30_ONE + 172272;
      r  = (r * u2) / Q30_ONE - 5026995;
      r  = (r * u2) / Q30_ONE + 85569306;
      r  = (r * u2) / Q30_ONE - 693598668;
      r  = (r * u2) / Q30_ONE + 1686629713;
      r  = (r * u) / Q30_ONE;
      if (r < 0) r = 0;
      r = (r + 32768) / 65536;
      if (r > 16384) r = 16384;
      lut[k] = SINE_BITS'(r);
    end
    return lut;
  endfunction

  // Offset of r/72 turn, rounded to the phase format
  function automatic offset_lut_t build_offset_lut();
    offset_lut_t lut;
    for (int r = 0; r < OFFSET_STEPS; r++) begin
      lut[r] = PHASE_BITS'(((longint'(r) << PHASE_BITS) + OFFSET_STEPS / 2) / OFFSET_STEPS);
    end
    return lut;
  endfunction

  // Step deadlines in whole ticks, rounded up; unused slots never trip
  function automatic deadline_lut_t build_deadline_lut();
    deadline_lut_t lut;
    for (int s = 0; s < (1 << STEP_BITS); s++) begin
      if (s < NUM_DEADLINES) begin
        lut[s] = 32'((DEADLINE_MS[s] + TICK_MILLISECONDS - 1) / TICK_MILLISECONDS);
      end else begin
        lut[s] = '1;
      end
    end
    return lut;
  endfunction

  localparam sine_lut_t     QUARTER_SINE   = build_sine_lut();
  localparam offset_lut_t   OFFSET_PHASE   = build_offset_lut();
  localparam deadline_lut_t DEADLINE_TICKS = build_deadline_lut();

endpackage

### design/sgs_front.sv
module sgs_front import sgs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  tick_i,
  input  logic [ID_BITS-1:0]    module_id_i,
  input  logic [PHASE_BITS-1:0] phase_step_i,
  input  logic                  full_i,
  output logic                  push_o,
  output cmd_t                  cmd_o
);

  logic [STEP_BITS-1:0]  step_q, step_d;
  logic [TICK_BITS-1:0]  ticks_q, ticks_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;

  logic                   live;
  logic                   fire;
  logic                   advance;
  logic                   run;
  logic [STEP_BITS-1:0]   next_step;
  logic                   emit;
  logic                   zero;
  div_e                   div;
  logic signed [7:0]      id_s;
  logic signed [7:0]      ofs;
  logic signed [7:0]      ofs_norm;
  logic [OFFSET_BITS-1:0] ofs_idx;
  logic [PHASE_BITS-1:0]  phase_sum;

  assign in_ready_o = !full_i;

  // Walk the timetable on each tick
  always_comb begin
    live      = step_q < STEP_FINISHED;
    fire      = in_valid_i && in_ready_o && tick_i && live;
    advance   = {{(32-TICK_BITS){1'b0}}, ticks_q} >= DEADLINE_TICKS[step_q];
    next_step = step_q + {{(STEP_BITS-1){1'b0}}, advance};
    run       = fire && (next_step < STEP_FINISHED);
  end

  // Classify the step: offset in 1/72 turn, head divisor, zero command
  always_comb begin
    id_s = {{(8-ID_BITS){1'b0}}, module_id_i};
    emit = 1'b0;
    zero = 1'b0;
    div  = DIV_ONE;
    ofs  = 8'sd0;
    if (module_id_i != '0) begin
      case (next_step)
        STEP_FORWARD: begin
          emit = 1'b1;
          ofs  = 8'sd9 * id_s;
          if (module_id_i == 3'd1) div = DIV_FOUR;
          else if (!module_id_i[0]) zero = 1'b1;
        end
        STEP_BACKWARD: begin
          emit = 1'b1;
          ofs  = -(8'sd9 * id_s);
          if (module_id_i == 3'd1) div = DIV_THREE;
          else if (!module_id_i[0]) zero = 1'b1;
        end
        STEP_ROTATE_CW: begin
          emit = 1'b1;
          ofs  = module_id_i[0] ? 8'sd0 : 8'sd18 * (id_s - 8'sd3);
        end
        STEP_ROTATE_CCW: begin
          emit = 1'b1;
          ofs  = module_id_i[0] ? 8'sd0 : 8'sd18 * (id_s - 8'sd1);
        end
        STEP_SIDEWIND_LEFT: begin
          emit = 1'b1;
          ofs  = module_id_i[0] ? -(8'sd12 * (id_s - 8'sd1))
                                : -(8'sd6 * (id_s - 8'sd2)) - 8'sd4;
        end
        STEP_SIDEWIND_RIGHT: begin
          emit = 1'b1;
          ofs  = module_id_i[0] ? 8'sd12 * (id_s - 8'sd1)
                                : 8'sd6 * (id_s - 8'sd2) + 8'sd4;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  // Fold the offset into one turn and add it to the phase
  always_comb begin
    if (ofs < 8'sd0) begin
      ofs_norm = ofs + 8'sd72;
    end else if (ofs >= 8'sd72) begin
      ofs_norm = ofs - 8'sd72;
    end else begin
      ofs_norm = ofs;
    end
    ofs_idx   = ofs_norm[OFFSET_BITS-1:0];
    phase_sum = phase_q + OFFSET_PHASE[ofs_idx];
  end

  assign push_o    = run && emit;
  assign cmd_o.idx  = phase_sum[PHASE_BITS-1 -: IDX_BITS];
  assign cmd_o.step = next_step;
  assign cmd_o.div  = div;
  assign cmd_o.zero = zero;

  // Advance step, phase and tick count
  always_comb begin
    step_d  = fire ? next_step : step_q;
    phase_d = run ? phase_q + phase_step_i : phase_q;
    ticks_d = (run && ticks_q != TICKS_MAX) ? ticks_q + 1'b1 : ticks_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_FORWARD;
      ticks_q <= '0;
      phase_q <= '0;
    end else begin
      step_q  <= step_d;
      ticks_q <= ticks_d;
      phase_q <= phase_d;
    end
  end

endmodule

### design/sgs_queue.sv
module sgs_queue import sgs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t                    mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_PTR_BITS:0]   count_q, count_d;
  logic                      do_push;
  logic                      do_pop;

  assign full_o  = count_q == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign cmd_o   = mem_q[rd_ptr_q];

  // Update pointers and fill count
  always_comb begin
    do_push  = push_i && !full_o;
    do_pop   = pop_i && !empty_o;
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + {{QUEUE_PTR_BITS{1'b0}}, do_push}
                       - {{QUEUE_PTR_BITS{1'b0}}, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### design/sgs_back.sv
module sgs_back import sgs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [AMP_BITS-1:0]  amplitude_i,
  input  cmd_t                 cmd_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [15:0]   joint_angle_o,
  output logic [STEP_BITS-1:0] gait_step_o
);

  logic en;

  // Stage 1: sine lookup
  logic                 s1_valid_q;
  logic [SINE_BITS-1:0] s1_mag_q;
  logic                 s1_neg_q;
  div_e                 s1_div_q;
  logic                 s1_zero_q;
  logic [STEP_BITS-1:0] s1_step_q;
  logic [1:0]           quad;
  logic [LUT_BITS-1:0]  lut_addr;

  // Stage 2: amplitude product
  logic                 s2_valid_q;
  logic [PROD_BITS-1:0] s2_prod_q;
  logic                 s2_neg_q;
  div_e                 s2_div_q;
  logic                 s2_zero_q;
  logic [STEP_BITS-1:0] s2_step_q;

  // Stage 3: rounded shift
  logic                 s3_valid_q;
  logic [QUOT_BITS-1:0] s3_x_q;
  logic [QUOT_BITS-1:0] s3_x_d;
  logic                 s3_third_q;
  logic                 s3_neg_q;
  logic                 s3_zero_q;
  logic [STEP_BITS-1:0] s3_step_q;

  // Output register
  logic                   out_valid_q;
  logic signed [15:0]     angle_q;
  logic signed [15:0]     angle_d;
  logic [STEP_BITS-1:0]   step_q;
  logic [2*QUOT_BITS-1:0] third_prod;
  logic [QUOT_BITS-1:0]   quot;

  // Move the whole pipe unless the output word is stuck
  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && !empty_i;

  always_comb begin
    quad     = cmd_i.idx[IDX_BITS-1 -: 2];
    lut_addr = quad[0] ? LUT_BITS'(QUARTER) - {1'b0, cmd_i.idx[QIDX_BITS-1:0]}
                       : {1'b0, cmd_i.idx[QIDX_BITS-1:0]};
  end

  always_comb begin
    case (s2_div_q)
      DIV_FOUR:  s3_x_d = QUOT_BITS'((s2_prod_q + BIAS_FOUR) >> ROUND_SHIFT_FOUR);
      DIV_THREE: s3_x_d = QUOT_BITS'((s2_prod_q + BIAS_THREE) >> ROUND_SHIFT_ONE);
      default:   s3_x_d = QUOT_BITS'((s2_prod_q + BIAS_ONE) >> ROUND_SHIFT_ONE);
    endcase
  end

  // Divide by three through the reciprocal, then apply the sign
  always_comb begin
    third_prod = {{QUOT_BITS{1'b0}}, s3_x_q} * {{QUOT_BITS{1'b0}}, RECIP_THIRD};
    quot       = s3_third_q ? QUOT_BITS'(third_prod >> RECIP_SHIFT) : s3_x_q;
    if (s3_zero_q) begin
      angle_d = '0;
    end else if (s3_neg_q) begin
      angle_d = -$signed(quot);
    end else begin
      angle_d = $signed(quot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= pop_o;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_mag_q   <= QUARTER_SINE[lut_addr];
      s1_neg_q   <= quad[1];
      s1_div_q   <= cmd_i.div;
      s1_zero_q  <= cmd_i.zero;
      s1_step_q  <= cmd_i.step;

      s2_prod_q  <= PROD_BITS'(amplitude_i) * PROD_BITS'(s1_mag_q);
      s2_neg_q   <= s1_neg_q;
      s2_div_q   <= s1_div_q;
      s2_zero_q  <= s1_zero_q;
      s2_step_q  <= s1_step_q;

      s3_x_q     <= s3_x_d;
      s3_third_q <= s2_div_q == DIV_THREE;
      s3_neg_q   <= s2_neg_q;
      s3_zero_q  <= s2_zero_q;
      s3_step_q  <= s2_step_q;

      angle_q    <= angle_d;
      step_q     <= s3_step_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign joint_angle_o = angle_q;
  assign gait_step_o   = step_q;

endmodule

### design/snake_gait_sequencer.sv
// Snake gait sequencer: each accepted word with tick set advances one control
// step through the nine-step gait timetable and, for a running step on a
// nonzero module, yields one joint angle (signed Q2.14 radians) tagged with
// the step that made it; ticks of zero, pause steps, module 0 and the
// finished state yield nothing. One input word is taken per clock while the
// four-entry command queue has room; a result passes through the command
// queue, then the back pipe registers for sine lookup, multiply, rounding,
// and divide and sign, and the back pipe retires one result per clock,
// stalling only while the output word waits. There is no startup sweep.
// Configuration writes (module id, amplitude, phase step) are taken at once
// and belong to idle periods.
module snake_gait_sequencer import sgs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     tick_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [15:0]       joint_angle_o,
  output logic [STEP_BITS-1:0]     gait_step_o
);

  logic [ID_BITS-1:0]    module_id_q;
  logic [AMP_BITS-1:0]   amplitude_q;
  logic [PHASE_BITS-1:0] phase_step_q;

  logic push;
  logic pop;
  logic full;
  logic empty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      module_id_q  <= MODULE_ID_RST;
      amplitude_q  <= AMPLITUDE_RST;
      phase_step_q <= PHASE_STEP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MODULE_ID:  module_id_q  <= cfg_data_i[ID_BITS-1:0];
        CFG_AMPLITUDE:  amplitude_q  <= cfg_data_i[AMP_BITS-1:0];
        CFG_PHASE_STEP: phase_step_q <= cfg_data_i[PHASE_BITS-1:0];
        default: ;
      endcase
    end
  end

  sgs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .tick_i       (tick_i),
    .module_id_i  (module_id_q),
    .phase_step_i (phase_step_q),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  sgs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .cmd_o   (head_cmd)
  );

  sgs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .amplitude_i   (amplitude_q),
    .cmd_i         (head_cmd),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .joint_angle_o (joint_angle_o),
    .gait_step_o   (gait_step_o)
  );

endmodule

### design/sgs_checker.sv
`include "assert_macros.svh"

module sgs_checker import sgs_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic signed [15:0]   joint_angle_o,
  input logic [STEP_BITS-1:0] gait_step_o
);

  logic                 seen_q;
  logic [STEP_BITS-1:0] last_step_q;
  logic                 step_runs;
  logic                 out_wait;

  // Flag the gait steps that drive the joint
  assign step_runs = gait_step_o inside {STEP_FORWARD, STEP_BACKWARD, STEP_ROTATE_CW,
                                         STEP_ROTATE_CCW, STEP_SIDEWIND_LEFT,
                                         STEP_SIDEWIND_RIGHT};
  assign out_wait  = out_valid_o && !out_ready_i;

  // Track the step of the last delivered word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      last_step_q <= STEP_FORWARD;
    end else if (out_valid_o && out_ready_i) begin
      seen_q      <= 1'b1;
      last_step_q <= gait_step_o;
    end
  end

  // No result is pending once reset has been seen
  `ASSERT_ALWAYS(a_reset_clears_out, clk_i, !rst_ni |=> !out_valid_o)

  // Only running gait steps produce words
  `ASSERT_CLK(a_step_runs, clk_i, rst_ni, out_valid_o |-> step_runs)

  // The timetable never goes back
  `ASSERT_CLK(a_step_monotonic, clk_i, rst_ni, out_valid_o && seen_q |-> gait_step_o >= last_step_q)

  // A stalled word holds
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_wait |=> out_valid_o && $stable({joint_angle_o, gait_step_o}))

endmodule

bind snake_gait_sequencer sgs_checker u_sgs_checker (.*);

### sim/gait_angle_checker.sv
`timescale 1ns / 1ps
module gait_angle_checker import sgs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic                     tick_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [15:0]       joint_angle_i,
  input  logic [STEP_BITS-1:0]     gait_step_i,
  output int                       pending_o,
  output int                       errors_o
);

  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint ONE_Q14 = 64'sd16384;
  localparam int     NUM_TIMED_STEPS = 9;

  // Cumulative end of each timed step in milliseconds
  localparam int STEP_END_MS [0:NUM_TIMED_STEPS-1] = '{
    10000, 20000, 22000, 29000, 36000, 38000, 45000, 52000, 62000};

  localparam logic [ID_BITS-1:0]    ID_AT_RESET   = 3'd0;
  localparam logic [AMP_BITS-1:0]   AMP_AT_RESET  = 15'd14746;
  localparam logic [PHASE_BITS-1:0] STEP_AT_RESET = 16'd2097;

  typedef struct packed {
    logic signed [15:0]   angle;
    logic [STEP_BITS-1:0] step;
  } joint_cmd_t;

  joint_cmd_t            pending_cmds[$];
  logic [ID_BITS-1:0]    module_id;
  logic [AMP_BITS-1:0]   amplitude;
  logic [PHASE_BITS-1:0] phase_step;
  logic [STEP_BITS-1:0]  step_idx;
  logic [TICK_BITS-1:0]  ticks;
  logic [PHASE_BITS-1:0] phase;
  int                    mismatches = 0;

  assign errors_o = mismatches;

  // sin(pi/2 * u) for u in Q30, odd polynomial, result in Q2.14
  function automatic longint quarter_wave(longint u);
    longint u2;
    longint r;
    u2 = (u * u) / Q30_ONE;
    r = 61;
    r = (r * u2) / Q30_ONE - 3864;
    r = (r * u2) / Q30_ONE + 172272;
    r = (r * u2) / Q30_ONE - 5026995;
    r = (r * u2) / Q30_ONE + 85569306;
    r = (r * u2) / Q30_ONE - 693598668;
    r = (r * u2) / Q30_ONE + 1686629713;
    r = (r * u) / Q30_ONE;
    if (r < 0) r = 0;
    r = (r + 32768) / 65536;
    if (r > ONE_Q14) r = ONE_Q14;
    return r;
  endfunction

  // Quantize the phase to the table grid and fold into the quarter wave
  function automatic longint sine_q14(logic [PHASE_BITS-1:0] ph);
    longint idx;
    longint four;
    longint quad;
    longint u;
    longint s;
    idx  = (longint'(ph) * SINE_TABLE_DEPTH) >>> PHASE_BITS;
    four = idx * 4;
    quad = (four / SINE_TABLE_DEPTH) & 3;
    u    = ((four % SINE_TABLE_DEPTH) << 30) / SINE_TABLE_DEPTH;
    s    = quad[0] ? quarter_wave(Q30_ONE - u) : quarter_wave(u);
    return (quad >= 2) ? -s : s;
  endfunction

  // Offset in 1/72 turn, wrapped and rounded to the phase format
  function automatic logic [PHASE_BITS-1:0] offset_turns(int o72);
    int r;
    r = ((o72 % 72) + 72) % 72;
    return PHASE_BITS'(((longint'(r) << PHASE_BITS) + 36) / 72);
  endfunction

  // Amplitude times sine, divided by one, three or four, rounded to nearest with ties away from zero
  function automatic logic signed [15:0] angle_for(int o72, div_e div);
    logic [PHASE_BITS-1:0] ph;
    longint num;
    longint den;
    longint mag;
    longint q;
    ph  = phase + offset_turns(o72);
    num = longint'(amplitude) * sine_q14(ph);
    case (div)
      DIV_THREE: den = 3 * ONE_Q14;
      DIV_FOUR:  den = 4 * ONE_Q14;
      default:   den = ONE_Q14;
    endcase
    mag = (num < 0) ? -num : num;
    q   = (mag + den / 2) / den;
    return 16'((num < 0) ? -q : q);
  endfunction

  // Advance the timetable by one tick and queue the command it yields
  function automatic void take_tick();
    int         id;
    bit         odd;
    bit         emit;
    joint_cmd_t cmd;
    id  = int'(module_id);
    odd = module_id[0];
    if (step_idx >= STEP_FINISHED) return;
    if (int'(ticks) * TICK_MILLISECONDS >= STEP_END_MS[step_idx]) step_idx++;
    if (step_idx >= STEP_FINISHED) return;
    emit      = (module_id != '0);
    cmd.step  = step_idx;
    cmd.angle = '0;
    if (emit) begin
      case (step_idx)
        STEP_FORWARD: begin
          if (id == 1) cmd.angle = angle_for(9 * id, DIV_FOUR);
          else if (odd) cmd.angle = angle_for(9 * id, DIV_ONE);
        end
        STEP_BACKWARD: begin
          if (id == 1) cmd.angle = angle_for(-9 * id, DIV_THREE);
          else if (odd) cmd.angle = angle_for(-9 * id, DIV_ONE);
        end
        STEP_ROTATE_CW: begin
          cmd.angle = odd ? angle_for(0, DIV_ONE) : angle_for(18 * (id - 3), DIV_ONE);
        end
        STEP_ROTATE_CCW: begin
          cmd.angle = odd ? angle_for(0, DIV_ONE) : angle_for(18 * (id - 1), DIV_ONE);
        end
        STEP_SIDEWIND_LEFT: begin
          cmd.angle = odd ? angle_for(-12 * (id - 1), DIV_ONE)
                          : angle_for(-6 * (id - 2) - 4, DIV_ONE);
        end
        STEP_SIDEWIND_RIGHT: begin
          cmd.angle = odd ? angle_for(12 * (id - 1), DIV_ONE)
                          : angle_for(6 * (id - 2) + 4, DIV_ONE);
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
    if (emit) pending_cmds.push_back(cmd);
    phase = phase + phase_step;
    if (ticks != '1) ticks++;
  endfunction

  // Track settings and ticks, compare every result word against the oldest command
  always @(posedge clk_i or negedge rst_ni) begin
    joint_cmd_t want;
    if (!rst_ni) begin
      module_id  = ID_AT_RESET;
      amplitude  = AMP_AT_RESET;
      phase_step = STEP_AT_RESET;
      step_idx   = STEP_FORWARD;
      ticks      = '0;
      phase      = '0;
      pending_cmds.delete();
      pending_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MODULE_ID:  module_id  = cfg_data_i[ID_BITS-1:0];
          CFG_AMPLITUDE:  amplitude  = cfg_data_i[AMP_BITS-1:0];
          CFG_PHASE_STEP: phase_step = cfg_data_i[PHASE_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i && tick_i) take_tick();
      if (out_valid_i && out_ready_i) begin
        if (pending_cmds.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected result word, angle %0d step %0d",
                     $time, joint_angle_i, gait_step_i);
          end
          mismatches++;
        end else begin
          want = pending_cmds.pop_front();
          if (joint_angle_i !== want.angle || gait_step_i !== want.step) begin
            if (mismatches < 10) begin
              $display("%0t: result word mismatch, expected angle %0d step %0d, got angle %0d step %0d",
                       $time, $signed(want.angle), want.step, joint_angle_i, gait_step_i);
            end
            mismatches++;
          end
        end
      end
      pending_o = pending_cmds.size();
    end
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import sgs_pkg::*;

  // Index with no register behind it
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 20;
  localparam int TICKS_TOTAL   = 1960;
  localparam int TICKS_STEADY  = 1760;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i  = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic                     tick_i      = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [15:0]       joint_angle_o;
  logic [STEP_BITS-1:0]     gait_step_o;

  int pending;
  int mismatches;
  int ticks_sent = 0;
  bit steady     = 1'b0;
  bit gappy      = 1'b1;

  always #10 clk_i = ~clk_i;

  snake_gait_sequencer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .tick_i        (tick_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .joint_angle_o (joint_angle_o),
    .gait_step_o   (gait_step_o)
  );

  gait_angle_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .tick_i        (tick_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .joint_angle_i (joint_angle_o),
    .gait_step_i   (gait_step_o),
    .pending_o     (pending),
    .errors_o      (mismatches)
  );

  // Offer one tick word, hold it until taken, then maybe pause the sender
  task automatic offer_tick(input logic t);
    logic took;
    in_valid_i <= 1'b1;
    tick_i     <= t;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    if (t) ticks_sent++;
    if (!steady && gappy && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // Write one register word and hold it until taken
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    logic took;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      took = cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
  endtask

  // Load all three registers; unused upper data bits are random
  task automatic set_gait(input logic [ID_BITS-1:0] id, input logic [AMP_BITS-1:0] amp,
                          input logic [PHASE_BITS-1:0] stp);
    write_reg(CFG_MODULE_ID, {13'($urandom), id});
    write_reg(CFG_AMPLITUDE, {1'($urandom), amp});
    write_reg(CFG_PHASE_STEP, stp);
    if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE, 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Stop sending, wait for every expected word, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Throttle the result side in random bursts, with long open stretches
  initial begin : result_throttle
    int run;
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      run = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
      repeat (run) @(posedge clk_i);
      if (!steady && $urandom_range(0, 2) != 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [ID_BITS-1:0]    id;
    logic [AMP_BITS-1:0]   amp;
    logic [PHASE_BITS-1:0] stp;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Module zero on reset settings: time moves, nothing comes out
    offer_tick(1'b0);
    offer_tick(1'b1);
    offer_tick(1'b1);
    drain();

    // Head at full amplitude and the largest phase step
    set_gait(3'd1, '1, '1);
    repeat (4) offer_tick(1'b1);
    offer_tick(1'b0);
    drain();

    // Even module in forward gait commands zero
    set_gait(3'd2, 15'd14746, 16'd2097);
    repeat (3) offer_tick(1'b1);
    drain();

    // Zero amplitude, zero phase step
    set_gait(3'd7, '0, '0);
    repeat (3) offer_tick(1'b1);
    drain();

    // Frozen phase at full amplitude, then the smallest nonzero settings
    set_gait(3'd5, '1, '0);
    repeat (3) offer_tick(1'b1);
    drain();
    set_gait(3'd6, 15'd1, 16'd1);
    repeat (3) offer_tick(1'b1);
    drain();

    // Walk the whole timetable and past its end, retuning between phases;
    // the closing stretch keeps its settings and runs without a break
    while (ticks_sent < TICKS_TOTAL) begin
      steady = (ticks_sent > TICKS_STEADY);
      if (!steady) begin
        gappy = ($urandom_range(0, 3) != 0);
        id    = 3'($urandom);
        case ($urandom_range(0, 5))
          0:       amp = '0;
          1:       amp = '1;
          default: amp = 15'($urandom);
        endcase
        case ($urandom_range(0, 7))
          0:       stp = '0;
          1:       stp = '1;
          2:       stp = 16'd1;
          3:       stp = 16'd2097;
          default: stp = 16'($urandom);
        endcase
        set_gait(id, amp, stp);
      end
      repeat ($urandom_range(8, 40)) offer_tick($urandom_range(0, 31) != 0);
      if (!steady) drain();
    end
    drain();

    if (mismatches == 0) begin
      $display("snake_gait_sequencer verification clean");
    end else begin
      $display("snake_gait_sequencer verification failed");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    #20000000;
    $display("snake_gait_sequencer verification failed");
    $finish;
  end

endmodule
